### hw/rtl/csqrt_pkg.sv
// Shared types, constants and helpers for the hyperbolic CORDIC square root.
// No dependencies; used by csqrt_kernel and cordic_square_root.
package csqrt_pkg;

    // Fixed-point format of operand and root
    localparam int FRAC_BITS     = 16;
    // Defaults for the top-level parameters
    localparam int WORK_BITS_DEF = 40;
    localparam int MAX_ITER_DEF  = 30;

    localparam logic [4:0]  ITER_RESET = 5'd20;
    // Gain correction 1.2074970677... for 20 steps, 32 fraction bits, rounded down
    localparam logic [32:0] GAIN_Q32   = 33'h1351E8720;
    localparam logic [23:0] ROOT_MAX   = 24'hFFFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_KERN,
        S_GAIN,
        S_SCALE
    } t_state;

    // Sequencer commands to the kernel
    typedef struct packed {
        logic load;
        logic step;
    } t_kern_ctrl;

    // Steps 4, 13, 40, ... (k -> 3k+1) run twice for convergence
    function automatic logic is_repeat(input logic [7:0] i);
        int   k;
        logic hit;
        hit = 1'b0;
        for (k = 4; k < 256; k = 3 * k + 1) begin
            if (i == 8'(k)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### hw/rtl/csqrt_kernel.sv
// Hyperbolic CORDIC x/y registers and the one shared shift-add step.
// Depends on csqrt_pkg (t_kern_ctrl).
module csqrt_kernel #(
    parameter int WORK_BITS = csqrt_pkg::WORK_BITS_DEF,
    parameter int CNT_W     = 5
) (
    input  logic                        i_clk,
    input  csqrt_pkg::t_kern_ctrl       i_ctrl,
    input  logic [WORK_BITS-1:0]        i_u,
    input  logic [CNT_W-1:0]            i_shift,
    output logic signed [WORK_BITS-1:0] o_x
);

    // 0.25 in the kernel format (WORK_BITS-4 fraction bits)
    localparam logic [WORK_BITS-1:0] QUARTER = WORK_BITS'(1) << (WORK_BITS - 6);

    logic signed [WORK_BITS-1:0] r_x, r_y;
    logic signed [WORK_BITS-1:0] n_x, n_y;
    logic signed [WORK_BITS-1:0] xs, ys;

    // One step: rotate towards y = 0, shifts floor towards minus infinity
    always_comb begin
        xs = r_x >>> i_shift;
        ys = r_y >>> i_shift;
        n_x = r_x;
        n_y = r_y;
        if (i_ctrl.load) begin
            n_x = $signed(i_u + QUARTER);
            n_y = $signed(i_u - QUARTER);
        end else if (i_ctrl.step) begin
            if (r_y[WORK_BITS-1]) begin
                n_x = r_x + ys;
                n_y = r_y + xs;
            end else begin
                n_x = r_x - ys;
                n_y = r_y - xs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_x = r_x;

endmodule

### hw/rtl/cordic_square_root.sv
// Square root of a signed Q16.16 request by hyperbolic CORDIC, unsigned Q8.16 root.
// Depends on csqrt_pkg and csqrt_kernel.
//
// A request is taken when start is high and busy is low; the result appears on
// o_root/o_status for exactly one cycle with o_valid high and cannot be stalled.
// A negative or zero operand is answered straight from the idle state; busy
// stays low. Any other operand passes through the normaliser, the kernel load,
// the CORDIC steps, the gain correction and the final scaling. The normaliser
// removes the j (0..15) leading zero bit pairs below the sign bit, one pair a
// cycle; the CORDIC kernel does one shift-add step per cycle, n steps (the
// configured step count, reset to 20 and capped at MAX_ITERATIONS) plus r
// repeats of steps 4 and 13 where they lie within n. busy is high until the
// result is shown, so a new request may already be taken in that same cycle.
module cordic_square_root #(
    parameter int WORK_BITS      = csqrt_pkg::WORK_BITS_DEF,
    parameter int MAX_ITERATIONS = csqrt_pkg::MAX_ITER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_operand,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    output logic               o_valid,
    output logic [23:0]        o_root,
    output logic               o_status
);

    localparam int F     = csqrt_pkg::FRAC_BITS;
    localparam int KF    = WORK_BITS - 4;
    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
    // Even exponent base for top bit at 30 or 29 (before the j pair shifts)
    localparam int C0_30 = 30 - F + ((30 + F) % 2);
    localparam int C0_29 = 29 - F + ((29 + F) % 2);
    // Shift from normalised word to kernel format
    localparam int D30   = KF - 30 - ((30 + F) % 2);
    localparam int D29   = KF - 29 - ((29 + F) % 2);
    localparam int POS30 = (D30 >= 0) ? D30 : 0;
    localparam int NEG30 = (D30 < 0) ? -D30 : 0;
    localparam int POS29 = (D29 >= 0) ? D29 : 0;
    localparam int NEG29 = (D29 < 0) ? -D29 : 0;
    localparam int UW    = 31 + ((POS30 > POS29) ? POS30 : POS29);
    // Final right shift before adding j; never negative over the FRAC_BITS range
    localparam int RS30  = 62 - F - C0_30 / 2;
    localparam int RS29  = 62 - F - C0_29 / 2;
    localparam int XW    = WORK_BITS + 30;

    csqrt_pkg::t_state     r_state, n_state;
    logic [4:0]            r_iter, n_iter;
    logic [30:0]           r_w, n_w;
    logic [3:0]            r_j, n_j;
    logic [CNT_W-1:0]      r_n, n_n;
    logic [CNT_W-1:0]      r_i, n_i;
    logic                  r_rep, n_rep;
    logic [63:0]           r_prod, n_prod;
    logic                  r_valid, n_valid;
    logic [23:0]           r_root, n_root;
    logic                  r_status, n_status;

    csqrt_pkg::t_kern_ctrl kctrl;
    logic                  w_top;
    logic [UW-1:0]         u_wide;
    logic [WORK_BITS-1:0]  u;
    logic [CNT_W-1:0]      n_eff;
    logic signed [WORK_BITS-1:0] kx;
    logic [WORK_BITS-1:0]  xc;
    logic [XW-1:0]         xw;
    logic [31:0]           xq;
    logic [64:0]           prod_full;
    logic [63:0]           prod_sat;
    logic [6:0]            rs;
    logic [63:0]           shifted;
    logic [23:0]           root_sat;

    csqrt_kernel #(
        .WORK_BITS (WORK_BITS),
        .CNT_W     (CNT_W)
    ) u_kernel (
        .i_clk   (i_clk),
        .i_ctrl  (kctrl),
        .i_u     (u),
        .i_shift (r_i),
        .o_x     (kx)
    );

    // Normalised word into kernel format; top bit position picks the shift
    always_comb begin
        w_top = r_w[30] | r_w[29];
        if (r_w[30]) begin
            u_wide = (UW'(r_w) >> NEG30) << POS30;
        end else begin
            u_wide = (UW'(r_w) >> NEG29) << POS29;
        end
        u = WORK_BITS'(u_wide);
    end

    // Step count, capped
    always_comb begin
        if (32'(r_iter) > MAX_ITERATIONS) begin
            n_eff = CNT_W'(MAX_ITERATIONS);
        end else begin
            n_eff = CNT_W'(r_iter);
        end
    end

    // Gain correction: x to 30 fraction bits, saturated, times the gain
    always_comb begin
        xc        = kx[WORK_BITS-1] ? '0 : kx;
        xw        = (XW'(xc) << 30) >> KF;
        xq        = (|xw[XW-1:32]) ? 32'hFFFFFFFF : xw[31:0];
        prod_full = 65'(xq) * 65'(csqrt_pkg::GAIN_Q32);
        prod_sat  = prod_full[64] ? 64'hFFFFFFFFFFFFFFFF : prod_full[63:0];
    end

    // Scale back by half the exponent and saturate to the root width
    always_comb begin
        rs       = (r_w[30] ? 7'(RS30) : 7'(RS29)) + 7'(r_j);
        shifted  = rs[6] ? '0 : (r_prod >> rs[5:0]);
        root_sat = (|shifted[63:24]) ? csqrt_pkg::ROOT_MAX : shifted[23:0];
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state  = r_state;
        n_iter   = i_cfg_we ? i_cfg_wdata : r_iter;
        n_w      = r_w;
        n_j      = r_j;
        n_n      = r_n;
        n_i      = r_i;
        n_rep    = r_rep;
        n_prod   = r_prod;
        n_valid  = 1'b0;
        n_root   = r_root;
        n_status = r_status;
        kctrl    = '0;
        busy     = (r_state != csqrt_pkg::S_IDLE);
        unique case (r_state)
            csqrt_pkg::S_IDLE: begin
                if (start) begin
                    if (i_operand[31]) begin
                        n_valid  = 1'b1;
                        n_root   = '0;
                        n_status = 1'b1;
                    end else if (i_operand == '0) begin
                        n_valid  = 1'b1;
                        n_root   = '0;
                        n_status = 1'b0;
                    end else begin
                        n_w     = i_operand[30:0];
                        n_j     = '0;
                        n_state = csqrt_pkg::S_NORM;
                    end
                end
            end
            csqrt_pkg::S_NORM: begin
                // shift by bit pairs so the exponent stays even
                if (w_top) begin
                    kctrl.load = 1'b1;
                    n_n        = n_eff;
                    n_i        = CNT_W'(1);
                    n_rep      = 1'b0;
                    n_state    = (n_eff == '0) ? csqrt_pkg::S_GAIN : csqrt_pkg::S_KERN;
                end else begin
                    n_w = r_w << 2;
                    n_j = r_j + 4'd1;
                end
            end
            csqrt_pkg::S_KERN: begin
                kctrl.step = 1'b1;
                if (csqrt_pkg::is_repeat(8'(r_i)) && !r_rep) begin
                    n_rep = 1'b1;
                end else begin
                    n_rep = 1'b0;
                    if (r_i == r_n) begin
                        n_state = csqrt_pkg::S_GAIN;
                    end else begin
                        n_i = r_i + CNT_W'(1);
                    end
                end
            end
            csqrt_pkg::S_GAIN: begin
                n_prod  = prod_sat;
                n_state = csqrt_pkg::S_SCALE;
            end
            csqrt_pkg::S_SCALE: begin
                n_valid  = 1'b1;
                n_root   = root_sat;
                n_status = 1'b0;
                n_state  = csqrt_pkg::S_IDLE;
            end
            default: begin
                n_state = csqrt_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csqrt_pkg::S_IDLE;
            r_iter  <= csqrt_pkg::ITER_RESET;
            r_valid <= 1'b0;
            r_rep   <= 1'b0;
            r_i     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_valid <= n_valid;
            r_rep   <= n_rep;
            r_i     <= n_i;
            r_n     <= n_n;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_j      <= n_j;
        r_prod   <= n_prod;
        r_root   <= n_root;
        r_status <= n_status;
    end

    assign o_valid  = r_valid;
    assign o_root   = r_root;
    assign o_status = r_status;

    // Checks
    a_neg_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operand[31]) |=> (o_valid && o_status))
        else $error("negative request not answered with undefined status");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_root == '0))
        else $error("undefined result carries a non-zero root");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_kern_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csqrt_pkg::S_KERN) |-> (r_i != '0 && r_i <= r_n))
        else $error("kernel step index out of range");

endmodule
